### rtl/ipv6_extension_chain_checker_assert.svh
// Assertion macros shared by the checker RTL.
`ifndef IPV6_EXTENSION_CHAIN_CHECKER_ASSERT_SVH
`define IPV6_EXTENSION_CHAIN_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define IECC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("iecc assertion failed");
// Checked on every edge, reset included.
`define IECC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("iecc assertion failed");
`else
`define IECC_ASSERT(lbl, clk, rst, prop)
`define IECC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/iecc_pkg.sv
`timescale 1ns / 1ps

package iecc_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int POS_W      = 17;

  localparam logic [7:0] NH_HOP   = 8'd0;
  localparam logic [7:0] NH_DEST  = 8'd60;
  localparam logic [7:0] NH_ROUTE = 8'd43;
  localparam logic [7:0] NH_FRAG  = 8'd44;
  localparam logic [7:0] NH_AUTH  = 8'd51;

  localparam logic [POS_W-1:0] HDR_BASE = 17'd40;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [1:0] VERDICT_DISCARD = 2'd1;
  localparam logic [1:0] VERDICT_PROBLEM = 2'd2;

  localparam logic [1:0] ICMP_BAD_HEADER = 2'd0;
  localparam logic [1:0] ICMP_UNKNOWN_OPT = 2'd2;

  localparam logic [7:0] OPT_PAD1         = 8'd0;
  localparam logic [7:0] OPT_PADN         = 8'd1;
  localparam logic [7:0] OPT_ROUTER_ALERT = 8'd5;
  localparam logic [7:0] RA_LEN           = 8'd2;

  localparam logic [1:0] ACT_SKIP         = 2'b00;
  localparam logic [1:0] ACT_DISCARD      = 2'b01;
  localparam logic [1:0] ACT_ICMP         = 2'b10;
  localparam logic [1:0] ACT_ICMP_UNICAST = 2'b11;

  typedef enum logic [13:0] {
    PH_IDLE      = 14'h0001,
    PH_HDR_FIRST = 14'h0002,
    PH_OPTH_LEN  = 14'h0004,
    PH_RT_LEN    = 14'h0008,
    PH_AH_LEN    = 14'h0010,
    PH_FRAG_RSV  = 14'h0020,
    PH_OPT_TYPE  = 14'h0040,
    PH_OPT_LEN   = 14'h0080,
    PH_OPT_DATA  = 14'h0100,
    PH_RT_TYPE   = 14'h0200,
    PH_RT_SEG    = 14'h0400,
    PH_FRAG_HI   = 14'h0800,
    PH_FRAG_LO   = 14'h1000,
    PH_SKIP      = 14'h2000
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  first_header_type;
    logic [15:0] payload_bytes;
    logic        dest_is_multicast;
    logic        addressed_here;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [POS_W-1:0] error_pointer;
    logic [1:0]       icmp_code;
    logic             multicast_reply_ok;
  } result_t;

  function automatic logic is_ext(input logic [7:0] t);
    is_ext = (t == NH_HOP) || (t == NH_DEST) || (t == NH_ROUTE) ||
             (t == NH_FRAG) || (t == NH_AUTH);
  endfunction

  function automatic result_t mk_result(input logic [1:0] v, input logic [POS_W-1:0] ptr,
                                        input logic [1:0] code, input logic mc);
    result_t r;
    r.verdict            = v;
    r.error_pointer      = ptr;
    r.icmp_code          = code;
    r.multicast_reply_ok = mc;
    mk_result = r;
  endfunction

endpackage

### rtl/iecc_walker.sv
`timescale 1ns / 1ps

module iecc_walker (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  iecc_pkg::item_t  item,
  input  logic             hbh_enable,
  output logic             res_valid,
  output iecc_pkg::result_t res
);
  import iecc_pkg::*;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] end_pos, end_pos_next;
  logic [7:0]       cur_type, cur_type_next;
  logic [POS_W-1:0] hdr_end, hdr_end_next;
  logic [7:0]       opt_left, opt_left_next;
  logic             inspect, inspect_next;
  logic [1:0]       flags, flags_next;
  logic [7:0]       frag_hi, frag_hi_next;

  logic [POS_W-1:0] pos1;
  logic [POS_W:0]   pos1_w;
  logic [POS_W-1:0] ptr_here;
  logic [POS_W-1:0] ptr_prev;
  logic [7:0]       optm1;
  logic [7:0]       b;

  assign b        = item.data_byte;
  assign pos1     = pos + 17'd1;
  assign pos1_w   = {1'b0, pos} + 18'd1;
  assign ptr_here = pos + HDR_BASE;
  assign ptr_prev = pos + HDR_BASE - 17'd1;
  assign optm1    = opt_left - 8'd1;

  always_comb begin
    logic done;
    logic skip_opt;
    done          = 1'b0;
    skip_opt      = 1'b0;
    res_valid     = 1'b0;
    res           = mk_result(VERDICT_ACCEPT, '0, ICMP_BAD_HEADER, 1'b0);
    phase_next    = phase;
    pos_next      = pos;
    end_pos_next  = end_pos;
    cur_type_next = cur_type;
    hdr_end_next  = hdr_end;
    opt_left_next = opt_left;
    inspect_next  = inspect;
    flags_next    = flags;
    frag_hi_next  = frag_hi;

    if (step && item.kind == KIND_START) begin
      cur_type_next = item.first_header_type;
      end_pos_next  = {1'b0, item.payload_bytes};
      flags_next    = {item.addressed_here, item.dest_is_multicast};
      pos_next      = '0;
      hdr_end_next  = '0;
      opt_left_next = '0;
      inspect_next  = 1'b0;
      frag_hi_next  = '0;
      if (item.payload_bytes == 16'd0 || !is_ext(item.first_header_type)) begin
        res_valid  = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_HDR_FIRST;
      end
    end else if (step && phase != PH_IDLE) begin
      unique case (phase)
        PH_HDR_FIRST: begin
          cur_type_next = b;
          if (cur_type == NH_HOP || cur_type == NH_DEST) begin
            inspect_next = (cur_type == NH_HOP) ? (hbh_enable | flags[1]) : flags[1];
            phase_next   = PH_OPTH_LEN;
          end else if (cur_type == NH_ROUTE) begin
            phase_next = PH_RT_LEN;
          end else if (cur_type == NH_AUTH) begin
            phase_next = PH_AH_LEN;
          end else begin
            hdr_end_next = pos + 17'd8;
            phase_next   = PH_FRAG_RSV;
          end
        end
        PH_OPTH_LEN: begin
          hdr_end_next = pos + {6'b0, b, 3'b0} + 17'd7;
          phase_next   = inspect ? PH_OPT_TYPE : PH_SKIP;
        end
        PH_RT_LEN: begin
          hdr_end_next = pos + {6'b0, b, 3'b0} + 17'd7;
          phase_next   = PH_RT_TYPE;
        end
        PH_AH_LEN: begin
          hdr_end_next = pos + {7'b0, b, 2'b0} + 17'd7;
          phase_next   = PH_SKIP;
        end
        PH_FRAG_RSV: phase_next = PH_FRAG_HI;
        PH_FRAG_HI: begin
          frag_hi_next = b;
          phase_next   = PH_FRAG_LO;
        end
        PH_FRAG_LO: begin
          // nonzero fragment offset: later fragment, accept
          if ({frag_hi, b[7:3]} != 13'd0) begin
            done = 1'b1;
            res  = mk_result(VERDICT_ACCEPT, '0, ICMP_BAD_HEADER, 1'b0);
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_RT_TYPE: phase_next = PH_RT_SEG;
        PH_RT_SEG: begin
          if (flags[1] && b != 8'd0) begin
            done = 1'b1;
            res  = mk_result(VERDICT_PROBLEM, ptr_prev, ICMP_BAD_HEADER, 1'b0);
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_OPT_TYPE: begin
          if (b != OPT_PAD1) begin
            if (pos1_w >= {1'b0, hdr_end}) begin
              done = 1'b1;
              res  = mk_result(VERDICT_PROBLEM, ptr_here, ICMP_BAD_HEADER, 1'b0);
            end else begin
              opt_left_next = b;
              phase_next    = PH_OPT_LEN;
            end
          end
        end
        PH_OPT_LEN: begin
          if (pos1_w + {10'b0, b} > {1'b0, hdr_end}) begin
            done = 1'b1;
            res  = mk_result(VERDICT_PROBLEM, ptr_here, ICMP_BAD_HEADER, 1'b0);
          end else if (opt_left == OPT_PADN) begin
            skip_opt = 1'b1;
          end else if (opt_left == OPT_ROUTER_ALERT) begin
            if (b != RA_LEN) begin
              done = 1'b1;
              res  = mk_result(VERDICT_PROBLEM, ptr_here, ICMP_BAD_HEADER, 1'b0);
            end else begin
              skip_opt = 1'b1;
            end
          end else begin
            case (opt_left[7:6])
              ACT_SKIP: skip_opt = 1'b1;
              ACT_DISCARD: begin
                done = 1'b1;
                res  = mk_result(VERDICT_DISCARD, '0, ICMP_BAD_HEADER, 1'b0);
              end
              ACT_ICMP: begin
                done = 1'b1;
                res  = mk_result(VERDICT_PROBLEM, ptr_prev, ICMP_UNKNOWN_OPT, 1'b1);
              end
              ACT_ICMP_UNICAST: begin
                done = 1'b1;
                if (flags[0]) begin
                  res = mk_result(VERDICT_DISCARD, '0, ICMP_BAD_HEADER, 1'b0);
                end else begin
                  res = mk_result(VERDICT_PROBLEM, ptr_prev, ICMP_UNKNOWN_OPT, 1'b0);
                end
              end
              default: skip_opt = 1'b1;
            endcase
          end
          if (skip_opt) begin
            if (b == 8'd0) begin
              phase_next = PH_OPT_TYPE;
            end else begin
              opt_left_next = b;
              phase_next    = PH_OPT_DATA;
            end
          end
        end
        PH_OPT_DATA: begin
          opt_left_next = optm1;
          if (optm1 == 8'd0) begin
            phase_next = PH_OPT_TYPE;
          end
        end
        PH_SKIP: ;
        default: ;
      endcase

      if (done) begin
        res_valid  = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        pos_next = pos1;
        if (phase_next != PH_HDR_FIRST && phase_next != PH_OPTH_LEN &&
            phase_next != PH_RT_LEN && phase_next != PH_AH_LEN &&
            pos1 == hdr_end_next) begin
          // end of header: go to the next in the chain, else accept
          if (pos1 >= end_pos || !is_ext(cur_type_next)) begin
            res_valid  = 1'b1;
            res        = mk_result(VERDICT_ACCEPT, '0, ICMP_BAD_HEADER, 1'b0);
            phase_next = PH_IDLE;
          end else begin
            phase_next = PH_HDR_FIRST;
          end
        end else if (pos1 >= end_pos) begin
          res_valid  = 1'b1;
          res        = mk_result(VERDICT_ACCEPT, '0, ICMP_BAD_HEADER, 1'b0);
          phase_next = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      pos      <= '0;
      end_pos  <= '0;
      cur_type <= '0;
      hdr_end  <= '0;
      opt_left <= '0;
      inspect  <= 1'b0;
      flags    <= '0;
      frag_hi  <= '0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      end_pos  <= end_pos_next;
      cur_type <= cur_type_next;
      hdr_end  <= hdr_end_next;
      opt_left <= opt_left_next;
      inspect  <= inspect_next;
      flags    <= flags_next;
      frag_hi  <= frag_hi_next;
    end
  end

`include "ipv6_extension_chain_checker_assert.svh"

  `IECC_ASSERT(a_res_needs_step, clk, rst, res_valid |-> step)
  `IECC_ASSERT(a_idle_after_verdict, clk, rst, res_valid |=> phase == PH_IDLE)
  `IECC_ASSERT(a_clean_accept, clk, rst,
    (res_valid && res.verdict != VERDICT_PROBLEM) |->
      (res.error_pointer == '0 && res.icmp_code == ICMP_BAD_HEADER && !res.multicast_reply_ok))

endmodule

### rtl/ipv6_extension_chain_checker.sv
`timescale 1ns / 1ps
// channel | dir | tvalid/tready      | payload
// s       | in  | s_tvalid/s_tready  | s_tuser: kind; s_tdata: first_header_type, payload_bytes,
//         |     |                    |   dest_is_multicast, addressed_here, data_byte
// m       | out | m_tvalid/m_tready  | m_tdata: verdict, error_pointer, icmp_code,
//         |     |                    |   multicast_reply_ok
// cfg     | in  | cfg_valid/cfg_ready| cfg_data: hop_by_hop_enable
//
// One beat per cycle while m_tready does not stall the result register; a verdict
// passes the input register, then the result register behind the header walker.
// Reset clears the walker to idle with no packet open and hop_by_hop_enable to 0.
// s_tready falls only while the input register holds a beat and the result register
// holds a verdict that m_tready has not taken. cfg_ready is always high.

module ipv6_extension_chain_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] first_header_type, [23:8] payload_bytes, [24] dest_is_multicast,
  // [25] addressed_here, [33:26] data_byte
  input  logic [iecc_pkg::IN_DATA_W-1:0]   s_tdata,
  // [0] kind
  input  logic                             s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [1:0] verdict, [18:2] error_pointer, [20:19] icmp_code, [21] multicast_reply_ok
  output logic [iecc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_data
);
  import iecc_pkg::*;

  logic    in_full;
  item_t   in_item;
  logic    advance;
  logic    hbh_enable;
  logic    res_valid;
  result_t res;

  assign advance   = in_full && (!m_tvalid || m_tready);
  assign s_tready  = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hbh_enable <= 1'b0;
    end else if (cfg_valid) begin
      hbh_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind              <= s_tuser;
      in_item.first_header_type <= s_tdata[7:0];
      in_item.payload_bytes     <= s_tdata[23:8];
      in_item.dest_is_multicast <= s_tdata[24];
      in_item.addressed_here    <= s_tdata[25];
      in_item.data_byte         <= s_tdata[33:26];
    end
  end

  iecc_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .item       (in_item),
    .hbh_enable (hbh_enable),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_tdata <= {2'b00, res.multicast_reply_ok, res.icmp_code, res.error_pointer, res.verdict};
    end
  end

`include "ipv6_extension_chain_checker_assert.svh"

  `IECC_ASSERT(a_in_hold, clk, rst,
    (in_full && m_tvalid && !m_tready) |=> (in_full && $stable(in_item)))
  `IECC_ASSERT(a_out_from_walker, clk, rst, $rose(m_tvalid) |-> $past(advance && res_valid))
  `IECC_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> (!in_full && !m_tvalid))

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import iecc_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  // [7:0] first_header_type, [23:8] payload_bytes, [24] dest_is_multicast,
  // [25] addressed_here, [33:26] data_byte
  logic [IN_DATA_W-1:0]  s_tdata;
  // [0] kind
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // [1:0] verdict, [18:2] error_pointer, [20:19] icmp_code, [21] multicast_reply_ok
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_data;

  ipv6_extension_chain_checker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // header walker state
  phase_t           walk_phase;
  logic [POS_W-1:0] walk_pos;
  logic [POS_W-1:0] walk_end;
  logic [POS_W-1:0] walk_hdr_end;
  logic [7:0]       walk_nh;
  logic [7:0]       walk_opt;
  logic [7:0]       walk_frag_hi;
  logic             walk_inspect;
  logic             walk_done;
  logic [1:0]       walk_flags;
  logic             hbh_enable;
  result_t          walk_res;

  result_t    verdict_q[$];
  logic [7:0] payload_q[$];
  int         items_sent;
  int         fail_count;
  int         sink_wait;
  bit         sink_burst;
  bit         src_burst;
  result_t    seen;
  result_t    want;

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic bit is_chain_header(logic [7:0] t);
    case (t)
      NH_HOP, NH_DEST, NH_ROUTE, NH_FRAG, NH_AUTH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void reset_walker();
    walk_phase   = PH_IDLE;
    walk_pos     = '0;
    walk_end     = '0;
    walk_hdr_end = '0;
    walk_nh      = '0;
    walk_opt     = '0;
    walk_frag_hi = '0;
    walk_inspect = 1'b0;
    walk_flags   = '0;
    walk_done    = 1'b1;
    hbh_enable   = 1'b0;
  endfunction

  function automatic bit post(logic [1:0] v, logic [POS_W-1:0] ptr, logic [1:0] code,
                              logic mc);
    walk_res.verdict            = v;
    walk_res.error_pointer      = ptr;
    walk_res.icmp_code          = code;
    walk_res.multicast_reply_ok = mc;
    walk_done  = 1'b1;
    walk_phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic bit accept_packet();
    return post(VERDICT_ACCEPT, '0, '0, 1'b0);
  endfunction

  function automatic bit discard_packet();
    return post(VERDICT_DISCARD, '0, '0, 1'b0);
  endfunction

  function automatic bit param_problem(int p, logic [1:0] code, logic mc);
    return post(VERDICT_PROBLEM, POS_W'(int'(HDR_BASE) + p), code, mc);
  endfunction

  function automatic bit enter_chain();
    if (walk_pos >= walk_end) return accept_packet();
    if (is_chain_header(walk_nh)) begin
      walk_phase = PH_HDR_FIRST;
      return 1'b0;
    end
    return accept_packet();
  endfunction

  function automatic void skip_option(logic [7:0] n);
    if (n == 8'd0) begin
      walk_phase = PH_OPT_TYPE;
    end else begin
      walk_opt   = n;
      walk_phase = PH_OPT_DATA;
    end
  endfunction

  function automatic bit walk_byte(logic [7:0] b);
    int          p;
    logic [7:0]  prev;
    logic [7:0]  t;
    logic [15:0] frag;
    p = int'(walk_pos);
    case (walk_phase)
      PH_HDR_FIRST: begin
        prev    = walk_nh;
        walk_nh = b;
        if (prev == NH_HOP || prev == NH_DEST) begin
          walk_inspect = (prev == NH_HOP) ? (hbh_enable | walk_flags[1]) : walk_flags[1];
          walk_phase   = PH_OPTH_LEN;
        end else if (prev == NH_ROUTE) begin
          walk_phase = PH_RT_LEN;
        end else if (prev == NH_AUTH) begin
          walk_phase = PH_AH_LEN;
        end else begin
          walk_hdr_end = POS_W'(p + 8);
          walk_phase   = PH_FRAG_RSV;
        end
      end
      PH_OPTH_LEN: begin
        walk_hdr_end = POS_W'(p - 1 + (int'(b) + 1) * 8);
        walk_phase   = walk_inspect ? PH_OPT_TYPE : PH_SKIP;
      end
      PH_RT_LEN: begin
        walk_hdr_end = POS_W'(p - 1 + (int'(b) + 1) * 8);
        walk_phase   = PH_RT_TYPE;
      end
      PH_AH_LEN: begin
        walk_hdr_end = POS_W'(p - 1 + (int'(b) + 2) * 4);
        walk_phase   = PH_SKIP;
      end
      PH_FRAG_RSV: walk_phase = PH_FRAG_HI;
      PH_FRAG_HI: begin
        walk_frag_hi = b;
        walk_phase   = PH_FRAG_LO;
      end
      PH_FRAG_LO: begin
        frag = {walk_frag_hi, b};
        if (frag[15:3] != 13'd0) return accept_packet();
        walk_phase = PH_SKIP;
      end
      PH_RT_TYPE: walk_phase = PH_RT_SEG;
      PH_RT_SEG: begin
        if (walk_flags[1] && b != 8'd0) return param_problem(p - 1, ICMP_BAD_HEADER, 1'b0);
        walk_phase = PH_SKIP;
      end
      PH_OPT_TYPE: begin
        if (b == OPT_PAD1) return 1'b0;
        if (p + 1 >= int'(walk_hdr_end)) return param_problem(p, ICMP_BAD_HEADER, 1'b0);
        walk_opt   = b;
        walk_phase = PH_OPT_LEN;
      end
      PH_OPT_LEN: begin
        t = walk_opt;
        if (p + 1 + int'(b) > int'(walk_hdr_end))
          return param_problem(p, ICMP_BAD_HEADER, 1'b0);
        if (t == OPT_PADN) begin
          skip_option(b);
          return 1'b0;
        end
        if (t == OPT_ROUTER_ALERT) begin
          if (b != RA_LEN) return param_problem(p, ICMP_BAD_HEADER, 1'b0);
          skip_option(b);
          return 1'b0;
        end
        case (t[7:6])
          ACT_SKIP: skip_option(b);
          ACT_DISCARD: return discard_packet();
          ACT_ICMP: return param_problem(p - 1, ICMP_UNKNOWN_OPT, 1'b1);
          default: begin
            if (walk_flags[0]) return discard_packet();
            return param_problem(p - 1, ICMP_UNKNOWN_OPT, 1'b0);
          end
        endcase
      end
      PH_OPT_DATA: begin
        walk_opt = walk_opt - 8'd1;
        if (walk_opt == 8'd0) walk_phase = PH_OPT_TYPE;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit predict_verdict(item_t it);
    if (it.kind == KIND_START) begin
      walk_nh      = it.first_header_type;
      walk_end     = {1'b0, it.payload_bytes};
      walk_flags   = {it.addressed_here, it.dest_is_multicast};
      walk_pos     = '0;
      walk_hdr_end = '0;
      walk_opt     = '0;
      walk_inspect = 1'b0;
      walk_frag_hi = '0;
      walk_done    = 1'b0;
      return enter_chain();
    end
    if (walk_done || walk_phase == PH_IDLE) return 1'b0;
    if (walk_byte(it.data_byte)) return 1'b1;
    walk_pos = walk_pos + 1'b1;
    if (!(walk_phase == PH_HDR_FIRST || walk_phase == PH_OPTH_LEN ||
          walk_phase == PH_RT_LEN || walk_phase == PH_AH_LEN) && walk_pos == walk_hdr_end)
      return enter_chain();
    if (walk_pos >= walk_end) return accept_packet();
    return 1'b0;
  endfunction

  function automatic item_t start_item(logic [7:0] nh, logic [15:0] plen, logic mc,
                                       logic here);
    item_t it;
    it.kind              = KIND_START;
    it.first_header_type = nh;
    it.payload_bytes     = plen;
    it.dest_is_multicast = mc;
    it.addressed_here    = here;
    it.data_byte         = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t byte_item(logic [7:0] b);
    item_t it;
    it.kind              = KIND_BYTE;
    it.first_header_type = 8'($urandom_range(0, 255));
    it.payload_bytes     = 16'($urandom_range(0, 65535));
    it.dest_is_multicast = 1'($urandom_range(0, 1));
    it.addressed_here    = 1'($urandom_range(0, 1));
    it.data_byte         = b;
    return it;
  endfunction

  function automatic logic [7:0] pick_ext();
    case ($urandom_range(0, 4))
      0: return NH_HOP;
      1: return NH_DEST;
      2: return NH_ROUTE;
      3: return NH_FRAG;
      default: return NH_AUTH;
    endcase
  endfunction

  function automatic logic [7:0] pick_upper();
    logic [7:0] t;
    t = 8'($urandom_range(0, 255));
    while (is_chain_header(t)) t = 8'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic void push_random(int n);
    repeat (n) payload_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void emit_options(logic [7:0] nh_next);
    int         units;
    int         room;
    int         n;
    int         pick;
    logic [7:0] t;
    units = $urandom_range(0, 2);
    room  = (units + 1) * 8 - 2;
    payload_q.push_back(nh_next);
    payload_q.push_back(8'(units));
    while (room > 0) begin
      pick = $urandom_range(0, 19);
      if (room < 2 || pick < 4) begin
        // a stray type octet in the last slot is a broken option
        if (room == 1 && pick == 0) payload_q.push_back(8'($urandom_range(1, 255)));
        else payload_q.push_back(OPT_PAD1);
        room--;
      end else begin
        if (pick < 9) t = OPT_PADN;
        else if (pick < 12) t = OPT_ROUTER_ALERT;
        else if (pick < 17) t = {ACT_SKIP, 6'($urandom_range(2, 63))};
        else t = {2'($urandom_range(1, 3)), 6'($urandom_range(0, 63))};
        if (t == OPT_ROUTER_ALERT && pick != 11) n = int'(RA_LEN);
        else n = $urandom_range(0, room - 2);
        if ($urandom_range(0, 29) == 0) n = room - 1;
        payload_q.push_back(t);
        payload_q.push_back(8'(n));
        if (n > room - 2) begin
          push_random(room - 2);
          room = 0;
        end else begin
          push_random(n);
          room = room - n - 2;
        end
      end
    end
  endfunction

  function automatic void emit_routing(logic [7:0] nh_next);
    int units;
    units = $urandom_range(0, 1);
    payload_q.push_back(nh_next);
    payload_q.push_back(8'(units));
    payload_q.push_back(8'($urandom_range(0, 255)));
    payload_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
    push_random((units + 1) * 8 - 4);
  endfunction

  function automatic void emit_fragment(logic [7:0] nh_next);
    logic [12:0] off;
    logic [2:0]  low;
    off = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8191)) : 13'd0;
    low = 3'($urandom_range(0, 7));
    payload_q.push_back(nh_next);
    payload_q.push_back(8'($urandom_range(0, 255)));
    payload_q.push_back(off[12:5]);
    payload_q.push_back({off[4:0], low});
    push_random(4);
  endfunction

  function automatic void emit_auth(logic [7:0] nh_next);
    int units;
    units = $urandom_range(0, 3);
    payload_q.push_back(nh_next);
    payload_q.push_back(8'(units));
    push_random((units + 2) * 4 - 2);
  endfunction

  function automatic logic [7:0] build_chain();
    logic [7:0] hdrs[$];
    int         n;
    int         i;
    payload_q.delete();
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) hdrs.push_back(pick_ext());
    hdrs.push_back(pick_upper());
    for (i = 0; i < n; i++) begin
      case (hdrs[i])
        NH_HOP, NH_DEST: emit_options(hdrs[i+1]);
        NH_ROUTE: emit_routing(hdrs[i+1]);
        NH_FRAG: emit_fragment(hdrs[i+1]);
        default: emit_auth(hdrs[i+1]);
      endcase
    end
    push_random($urandom_range(0, 3));
    return hdrs[0];
  endfunction

  function automatic void load_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                     logic [7:0] b3);
    payload_q.delete();
    payload_q.push_back(b0);
    payload_q.push_back(b1);
    payload_q.push_back(b2);
    payload_q.push_back(b3);
  endfunction

  task automatic send_item(item_t it);
    int                   gap;
    logic [IN_DATA_W-1:0] beat;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    beat         = '0;
    beat[7:0]    = it.first_header_type;
    beat[23:8]   = it.payload_bytes;
    beat[24]     = it.dest_is_multicast;
    beat[25]     = it.addressed_here;
    beat[33:26]  = it.data_byte;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (predict_verdict(it)) verdict_q.push_back(walk_res);
    items_sent++;
  endtask

  task automatic send_packet(logic [7:0] nh, logic [15:0] plen, logic mc, logic here,
                             int nsend);
    int i;
    send_item(start_item(nh, plen, mc, here));
    for (i = 0; i < nsend && i < payload_q.size(); i++) send_item(byte_item(payload_q[i]));
  endtask

  // close any open packet with an empty one, then let the pipeline drain
  task automatic settle();
    send_item(start_item(pick_upper(), 16'd0, 1'b0, 1'b0));
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_hop_by_hop(logic v);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    hbh_enable = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_boundary_cases();
    logic [7:0] upper;
    upper = pick_upper();
    payload_q.delete();
    send_packet(NH_HOP, 16'd0, 1'b0, 1'b0, 0);
    send_item(byte_item(8'hFF));
    send_packet(8'hFF, 16'hFFFF, 1'b1, 1'b1, 0);
    send_item(byte_item(8'h00));
    // unknown option asking for an error even to multicast
    load_bytes(upper, 8'd0, {ACT_ICMP, 6'h3F}, 8'd0);
    send_packet(NH_HOP, 16'd8, 1'b1, 1'b1, 4);
    // routing header with segments left
    load_bytes(upper, 8'd0, 8'd0, 8'hFF);
    send_packet(NH_ROUTE, 16'd8, 1'b0, 1'b1, 4);
    // non-first fragment
    load_bytes(upper, 8'd0, 8'hFF, 8'hF8);
    send_packet(NH_FRAG, 16'd8, 1'b0, 1'b1, 4);
    // payload ends inside a header
    load_bytes(upper, 8'hFF, 8'd0, 8'd0);
    send_packet(NH_AUTH, 16'd2, 1'b0, 1'b1, 2);
    // left open, dropped by the next start
    load_bytes(upper, 8'd0, 8'd0, 8'd0);
    send_packet(NH_DEST, 16'hFFFF, 1'b0, 1'b1, 2);
  endtask

  task automatic test_option_chains(int upto);
    logic [7:0]  first;
    logic [15:0] plen;
    int          sz;
    int          pick;
    int          nsend;
    while (items_sent < upto) begin
      first = build_chain();
      sz    = payload_q.size();
      pick  = $urandom_range(0, 19);
      if (pick < 13) plen = 16'(sz);
      else if (pick < 16) plen = 16'($urandom_range(0, sz));
      else if (pick < 19) plen = 16'(sz + $urandom_range(1, 64));
      else plen = 16'($urandom_range(sz, 65535));
      nsend = ($urandom_range(0, 19) == 0) ? $urandom_range(0, sz) : sz;
      send_packet(first, plen, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0), nsend);
    end
  endtask

  task automatic test_noise_items(int upto);
    logic [7:0]  first;
    logic [15:0] plen;
    int          pick;
    int          n;
    while (items_sent < upto) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        send_item(byte_item(8'($urandom_range(0, 255))));
      end else if (pick < 6) begin
        payload_q.delete();
        n = $urandom_range(0, 24);
        push_random(n);
        first = $urandom_range(0, 1) ? pick_ext() : 8'($urandom_range(0, 255));
        plen  = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 40))
                                             : 16'($urandom_range(0, 65535));
        send_packet(first, plen, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), n);
      end else begin
        first = build_chain();
        if (payload_q.size() != 0)
          payload_q[$urandom_range(0, payload_q.size() - 1)] = 8'($urandom_range(0, 255));
        send_packet(first, 16'(payload_q.size()), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), payload_q.size());
      end
    end
  endtask

  always @(negedge clk) begin
    if (sink_wait > 0) begin
      m_tready  <= 1'b0;
      sink_wait = sink_wait - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.verdict            = m_tdata[1:0];
      seen.error_pointer      = m_tdata[18:2];
      seen.icmp_code          = m_tdata[20:19];
      seen.multicast_reply_ok = m_tdata[21];
      if (verdict_q.size() == 0) begin
        note_fail($sformatf("unexpected verdict %0d ptr %0d code %0d mc %0d", seen.verdict,
                            seen.error_pointer, seen.icmp_code, seen.multicast_reply_ok));
      end else begin
        want = verdict_q.pop_front();
        if (seen.verdict !== want.verdict || seen.error_pointer !== want.error_pointer ||
            seen.icmp_code !== want.icmp_code ||
            seen.multicast_reply_ok !== want.multicast_reply_ok)
          note_fail($sformatf(
            "mismatch: verdict %0d/%0d ptr %0d/%0d code %0d/%0d mc %0d/%0d (exp/got)",
            want.verdict, seen.verdict, want.error_pointer, seen.error_pointer,
            want.icmp_code, seen.icmp_code, want.multicast_reply_ok,
            seen.multicast_reply_ok));
      end
      sink_wait = sink_burst ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
    end
  end

  initial begin
    int waited;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = KIND_START;
    cfg_valid  = 1'b0;
    cfg_data   = 1'b0;
    m_tready   = 1'b0;
    sink_wait  = 0;
    sink_burst = 1'b0;
    src_burst  = 1'b0;
    items_sent = 0;
    fail_count = 0;
    reset_walker();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_hop_by_hop(1'b0);
    test_boundary_cases();
    set_hop_by_hop(1'b1);
    test_option_chains(600);
    set_hop_by_hop(1'b0);
    test_option_chains(1100);
    test_noise_items(1300);
    set_hop_by_hop(1'b1);
    test_option_chains(1550);

    @(negedge clk);
    s_tvalid <= 1'b0;
    waited = 0;
    while (verdict_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (verdict_q.size() != 0)
      note_fail($sformatf("%0d expected verdicts never arrived", verdict_q.size()));

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
